[rtl/core/lict_pkg.sv]
// Package: shared types and register map constants for the local interrupt timer block.
package lict_pkg;

   // Item kinds on the request channel; the fourth code does nothing.
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   // Register offsets, in 16-byte units (reg_offset[11:4]).
   localparam logic [7:0] OFS_ID    = 8'h02;
   localparam logic [7:0] OFS_VER   = 8'h03;
   localparam logic [7:0] OFS_TPR   = 8'h08;
   localparam logic [7:0] OFS_EOI   = 8'h0B;
   localparam logic [7:0] OFS_SVR   = 8'h0F;
   localparam logic [7:0] OFS_ICRLO = 8'h30;
   localparam logic [7:0] OFS_ICRHI = 8'h31;
   localparam logic [7:0] OFS_LVT   = 8'h32;
   localparam logic [7:0] OFS_TICR  = 8'h38;
   localparam logic [7:0] OFS_TCCR  = 8'h39;
   localparam logic [7:0] OFS_TDCR  = 8'h3E;

   // Bit positions.
   localparam int unsigned BUSY_BIT   = 12;
   localparam int unsigned ENABLE_BIT = 8;
   localparam int unsigned PERIOD_BIT = 17;

   // Configuration register indexes.
   localparam logic CSR_PROC_ID = 1'b0;
   localparam logic CSR_VERSION = 1'b1;

   localparam logic [7:0] VERSION_RESET = 8'd20;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] reg_offset;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        timer_fire;
      logic [7:0]  timer_vector;
      logic        eoi_seen;
      logic        ipi_send;
      logic [7:0]  ipi_dest;
      logic [15:0] ipi_command;
   } rsp_type;

endpackage

[rtl/core/lict_chan_if.sv]
// Interface: valid/ready channel carrying one payload per transfer.
interface lict_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/local_interrupt_controller_timer.sv]
// Top level: local interrupt controller register subset with countdown timer.
// Each request is a timer tick, a register read or a register write (offset in a 4 KiB
// window, bits 3..0 ignored); each produces exactly one response. A request is held in an
// input register until the output register can take it; then the register file and timer
// are updated and the response is captured in the output register. One request can be
// taken every cycle while responses are accepted; the read mux / counter decrement lies
// between the two registers. The request side keeps flowing while a response waits,
// as long as the output register frees up in the same cycle. Unknown offsets read zero;
// only divide-by-one is modeled. csr_* sets processor ID and version; write only when idle.
module local_interrupt_controller_timer import lict_pkg::*; #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   lict_chan_if.sink   req_chan,
   lict_chan_if.source rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   // input stage
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   // output stage
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;

   logic    advance;   // input stage item moves to output stage this cycle
   logic    req_xfer;
   rsp_type result;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   // state update happens as the item leaves the input register
   lict_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .go        (advance),
      .item      (in_item_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= req_chan.payload;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

   // every item leaving the input stage lands in the output stage
   assert property (@(posedge clock) disable iff (reset) advance |=> out_valid_ff)
      else $error("response lost from output stage");

   // a held response is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("output stage overwritten while stalled");

   // a firing tick carries nothing else
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.timer_fire |->
         out_item_ff.read_data == 32'd0 && !out_item_ff.eoi_seen && !out_item_ff.ipi_send)
      else $error("timer fire mixed with other response fields");

   // issued command never shows busy, and idle fields stay zero
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |->
         (out_item_ff.ipi_send ? !out_item_ff.ipi_command[BUSY_BIT]
                               : (out_item_ff.ipi_command == 16'd0 &&
                                  out_item_ff.ipi_dest == 8'd0)))
      else $error("bad interrupt command fields");

endmodule

[rtl/core/lict_core.sv]
// Register file, timer counter and per-item result logic.
module lict_core import lict_pkg::*; #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        go,
   input  req_type     item,
   output rsp_type     result
);

   logic [7:0]             proc_id_ff;
   logic [7:0]             version_ff;
   logic [COUNT_WIDTH-1:0] initial_ff, initial_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [7:0]             vector_ff, vector_in;
   logic                   periodic_ff, periodic_in;
   logic [8:0]             svr_ff, svr_in;
   logic [7:0]             tpr_ff, tpr_in;
   logic [3:0]             divide_ff, divide_in;
   logic [15:0]            cmd_low_ff, cmd_low_in;
   logic [7:0]             cmd_dest_ff, cmd_dest_in;
   logic [7:0]             ofs;
   logic [31:0]            wdata;
   logic [31:0]            rdata;

   assign ofs   = item.reg_offset[11:4];
   assign wdata = item.write_data;

   // Read mux
   always_comb begin
      case (ofs)
         OFS_ID:    rdata = {proc_id_ff, 24'd0};
         OFS_VER:   rdata = {24'd0, version_ff};
         OFS_TPR:   rdata = {24'd0, tpr_ff};
         OFS_SVR:   rdata = {23'd0, svr_ff};
         OFS_ICRLO: rdata = {16'd0, cmd_low_ff};
         OFS_ICRHI: rdata = {cmd_dest_ff, 24'd0};
         OFS_LVT:   rdata = {14'd0, periodic_ff, 9'd0, vector_ff};
         OFS_TICR:  rdata = 32'(initial_ff);
         OFS_TCCR:  rdata = 32'(count_ff);
         OFS_TDCR:  rdata = {28'd0, divide_ff};
         default:   rdata = 32'd0;
      endcase
   end

   always_comb begin
      initial_in  = initial_ff;
      count_in    = count_ff;
      vector_in   = vector_ff;
      periodic_in = periodic_ff;
      svr_in      = svr_ff;
      tpr_in      = tpr_ff;
      divide_in   = divide_ff;
      cmd_low_in  = cmd_low_ff;
      cmd_dest_in = cmd_dest_ff;
      result      = '0;
      case (mode_type'(item.mode))
         MODE_TICK: begin
            cmd_low_in[BUSY_BIT] = 1'b0;
            if (svr_ff[ENABLE_BIT] && (count_ff != '0)) begin
               count_in = count_ff - COUNT_WIDTH'(1);
               if (count_ff == COUNT_WIDTH'(1)) begin
                  result.timer_fire   = 1'b1;
                  result.timer_vector = vector_ff;
                  if (periodic_ff) begin
                     count_in = initial_ff;
                  end
               end
            end
         end
         MODE_READ: begin
            result.read_data = rdata;
         end
         MODE_WRITE: begin
            case (ofs)
               OFS_TPR: tpr_in = wdata[7:0];
               OFS_EOI: result.eoi_seen = 1'b1;
               OFS_SVR: svr_in = wdata[8:0];
               OFS_ICRLO: begin
                  result.ipi_command           = wdata[15:0];
                  result.ipi_command[BUSY_BIT] = 1'b0;
                  result.ipi_send              = 1'b1;
                  result.ipi_dest              = cmd_dest_ff;
                  cmd_low_in                   = wdata[15:0];
                  cmd_low_in[BUSY_BIT]         = 1'b1;
               end
               OFS_ICRHI: cmd_dest_in = wdata[31:24];
               OFS_LVT: begin
                  vector_in   = wdata[7:0];
                  periodic_in = wdata[PERIOD_BIT];
               end
               OFS_TICR: begin
                  initial_in = wdata[COUNT_WIDTH-1:0];
                  count_in   = wdata[COUNT_WIDTH-1:0];
               end
               OFS_TDCR: divide_in = {wdata[3], 1'b0, wdata[1:0]};
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proc_id_ff  <= '0;
         version_ff  <= VERSION_RESET;
         initial_ff  <= '0;
         count_ff    <= '0;
         vector_ff   <= '0;
         periodic_ff <= 1'b0;
         svr_ff      <= '0;
         tpr_ff      <= '0;
         divide_ff   <= '0;
         cmd_low_ff  <= '0;
         cmd_dest_ff <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PROC_ID: proc_id_ff <= csr_wdata;
               CSR_VERSION: version_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (go) begin
            initial_ff  <= initial_in;
            count_ff    <= count_in;
            vector_ff   <= vector_in;
            periodic_ff <= periodic_in;
            svr_ff      <= svr_in;
            tpr_ff      <= tpr_in;
            divide_ff   <= divide_in;
            cmd_low_ff  <= cmd_low_in;
            cmd_dest_ff <= cmd_dest_in;
         end
      end
   end

endmodule
